### design/mkt_pkg.sv
// mkt_pkg: shared types, codes and constants for the morse keyer tone generator
// no dependencies; used by every module of the block
`default_nettype none

package mkt_pkg;

    localparam int SPU_W   = 20;
    localparam int OSC_W   = 32;
    localparam int AMP_W   = 15;
    localparam int PCM_W   = 16;
    localparam int Q_SHIFT = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SPU_W-1:0]        SPU_RST   = 20'd2880;
    localparam logic signed [OSC_W-1:0] COEFF_RST = 32'sh7FFF_FFFF;
    localparam logic [AMP_W-1:0]        AMP_RST   = 15'd16384;
    localparam logic signed [OSC_W-1:0] SEED_RST  = 32'sd0;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [1:0] {
        SYM_DIT   = 2'd0,
        SYM_DAH   = 2'd1,
        SYM_SPACE = 2'd2
    } sym_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPU   = 2'd0,
        REG_COEFF = 2'd1,
        REG_SINE  = 2'd2,
        REG_AMP   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic       action;
        logic [1:0] symbol;
    } in_t;

    typedef struct packed {
        logic signed [PCM_W-1:0] sample;
        logic                    tone_on;
        logic                    last;
    } out_t;

    // sequencer status towards the top level and the oscillator
    typedef struct packed {
        logic busy;
        logic result;
        logic tone;
        logic last;
    } seq_st_t;

endpackage

`default_nettype wire

### design/mkt_seq.sv
// mkt_seq: symbol sequencer, unit sample counter and tone/silence unit counts
// depends on mkt_pkg
`default_nettype none

module mkt_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       fire,
    input  wire mkt_pkg::in_t               item,
    input  wire logic [mkt_pkg::SPU_W-1:0]  spu,
    output mkt_pkg::seq_st_t                st
);

    logic [mkt_pkg::SPU_W-1:0] cnt_reg, cnt_next;
    logic [2:0]                units_reg, units_next;
    logic [1:0]                tone_reg, tone_next;
    logic                      busy_reg, busy_next;

    logic [mkt_pkg::SPU_W-1:0] cnt_inc;
    logic [mkt_pkg::SPU_W-1:0] limit;
    logic                      result;
    logic                      tone;
    logic                      last;

    always_comb
    begin
        cnt_next   = cnt_reg;
        units_next = units_reg;
        tone_next  = tone_reg;
        busy_next  = busy_reg;
        result     = 1'b0;
        tone       = 1'b0;
        last       = 1'b0;
        cnt_inc    = cnt_reg + 1'b1;
        limit      = (spu == '0) ? {{(mkt_pkg::SPU_W-1){1'b0}}, 1'b1} : spu;

        if (fire)
        begin
            if (item.action == mkt_pkg::ACT_LOAD)
            begin
                if (!busy_reg)
                begin
                    case (mkt_pkg::sym_t'(item.symbol))
                        mkt_pkg::SYM_DIT:
                        begin
                            units_next = 3'd2;
                            tone_next  = 2'd1;
                            cnt_next   = '0;
                            busy_next  = 1'b1;
                        end
                        mkt_pkg::SYM_DAH:
                        begin
                            units_next = 3'd4;
                            tone_next  = 2'd3;
                            cnt_next   = '0;
                            busy_next  = 1'b1;
                        end
                        mkt_pkg::SYM_SPACE:
                        begin
                            units_next = 3'd2;
                            tone_next  = 2'd0;
                            cnt_next   = '0;
                            busy_next  = 1'b1;
                        end
                        default:
                        begin
                            busy_next = busy_reg;
                        end
                    endcase
                end
            end
            else if (busy_reg)
            begin
                result   = 1'b1;
                tone     = (tone_reg != 2'd0);
                cnt_next = cnt_inc;
                // unit boundary, also on counter wrap
                if ((cnt_inc >= limit) || (cnt_inc == '0))
                begin
                    cnt_next = '0;
                    if (tone_reg != 2'd0)
                    begin
                        tone_next = tone_reg - 2'd1;
                    end
                    if (units_reg != 3'd0)
                    begin
                        units_next = units_reg - 3'd1;
                    end
                    if (units_next == 3'd0)
                    begin
                        busy_next = 1'b0;
                        tone_next = 2'd0;
                        last      = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            units_reg <= '0;
            tone_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            units_reg <= units_next;
            tone_reg  <= tone_next;
            busy_reg  <= busy_next;
        end
    end

    assign st = '{busy: busy_reg, result: result, tone: tone, last: last};

endmodule

`default_nettype wire

### design/mkt_osc.sv
// mkt_osc: q2.30 two-term resonator and amplitude scaling to 16-bit pcm
// depends on mkt_pkg
`default_nettype none

module mkt_osc (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic                              reseed,
    input  wire logic signed [mkt_pkg::OSC_W-1:0]  seed,
    input  wire logic signed [mkt_pkg::OSC_W-1:0]  coeff,
    input  wire logic [mkt_pkg::AMP_W-1:0]         amplitude,
    output logic signed [mkt_pkg::PCM_W-1:0]       sample
);

    localparam int PROD_W  = 2 * mkt_pkg::OSC_W;
    localparam int Q_W     = PROD_W - mkt_pkg::Q_SHIFT;
    localparam int SPROD_W = mkt_pkg::OSC_W + mkt_pkg::AMP_W;
    localparam int SC_W    = SPROD_W - mkt_pkg::Q_SHIFT;
    localparam logic signed [SPROD_W-1:0] TRUNC_BIAS =
        SPROD_W'((64'd1 << mkt_pkg::Q_SHIFT) - 64'd1);
    localparam logic signed [SC_W-1:0] PCM_POS = SC_W'(32767);
    localparam logic signed [SC_W-1:0] PCM_NEG = -SC_W'(32767);

    logic signed [mkt_pkg::OSC_W-1:0] prev_reg, prev_next;
    logic signed [mkt_pkg::OSC_W-1:0] cur_reg, cur_next;

    logic signed [PROD_W-1:0]         prod;
    logic signed [Q_W-1:0]            q;
    logic signed [Q_W:0]              diff;
    logic signed [mkt_pkg::OSC_W-1:0] nxt;
    logic signed [SPROD_W-1:0]        sprod;
    logic signed [SPROD_W-1:0]        sbias;
    logic signed [SC_W-1:0]           sc;

    // resonator step, floor shift then saturate
    always_comb
    begin
        prod = coeff * cur_reg;
        q    = prod[PROD_W-1:mkt_pkg::Q_SHIFT];
        diff = {q[Q_W-1], q}
             - {{(Q_W+1-mkt_pkg::OSC_W){prev_reg[mkt_pkg::OSC_W-1]}}, prev_reg};
        if (diff[Q_W:mkt_pkg::OSC_W-1] == '0 || diff[Q_W:mkt_pkg::OSC_W-1] == '1)
        begin
            nxt = diff[mkt_pkg::OSC_W-1:0];
        end
        else if (diff[Q_W])
        begin
            nxt = {1'b1, {(mkt_pkg::OSC_W-1){1'b0}}};
        end
        else
        begin
            nxt = {1'b0, {(mkt_pkg::OSC_W-1){1'b1}}};
        end
    end

    // scaling, truncation toward zero and pcm saturation
    always_comb
    begin
        sprod = prev_reg * $signed({1'b0, amplitude});
        sbias = sprod + (sprod[SPROD_W-1] ? TRUNC_BIAS : '0);
        sc    = sbias[SPROD_W-1:mkt_pkg::Q_SHIFT];
        if (sc > PCM_POS)
        begin
            sample = PCM_POS[mkt_pkg::PCM_W-1:0];
        end
        else if (sc < PCM_NEG)
        begin
            sample = PCM_NEG[mkt_pkg::PCM_W-1:0];
        end
        else
        begin
            sample = sc[mkt_pkg::PCM_W-1:0];
        end
    end

    always_comb
    begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        if (reseed)
        begin
            prev_next = '0;
            cur_next  = seed;
        end
        else if (advance)
        begin
            prev_next = cur_reg;
            cur_next  = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            cur_reg  <= mkt_pkg::SEED_RST;
        end
        else
        begin
            prev_reg <= prev_next;
            cur_reg  <= cur_next;
        end
    end

endmodule

`default_nettype wire

### design/morse_keyer_tone_generator.sv
// morse_keyer_tone_generator: top level with input register, config registers and result register
// depends on mkt_pkg, mkt_seq, mkt_osc
//
//   channel | direction | handshake           | payload
//   in      | in        | in_valid/in_ready   | in_data  (action, symbol)
//   out     | out       | out_valid/out_ready | out_data (sample, tone_on, last)
//   cfg     | in        | cfg_wen             | cfg_index, cfg_data
//
// one transfer per cycle per side unless stalled; ticks pass the input, then the result register
// the resonator step and the amplitude multiply run in parallel in the working stage
// rst_n clears the handshake and sequencer state and restores the register defaults
// a stalled result holds the working stage; in_ready drops only when both stages are full
`default_nettype none

module morse_keyer_tone_generator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire mkt_pkg::in_t                        in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output mkt_pkg::out_t                            out_data,
    input  wire logic                                cfg_wen,
    input  wire logic [mkt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mkt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                              in_vld_reg, in_vld_next;
    mkt_pkg::in_t                      in_item_reg, in_item_next;
    logic                              out_vld_reg, out_vld_next;
    mkt_pkg::out_t                     out_item_reg, out_item_next;
    logic [mkt_pkg::SPU_W-1:0]         spu_reg, spu_next;
    logic signed [mkt_pkg::OSC_W-1:0]  coeff_reg, coeff_next;
    logic [mkt_pkg::AMP_W-1:0]         amp_reg, amp_next;

    logic                              proc;
    logic                              reseed;
    mkt_pkg::seq_st_t                  seq_st;
    logic signed [mkt_pkg::PCM_W-1:0]  osc_sample;

    assign proc     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || proc;
    assign reseed   = cfg_wen && (mkt_pkg::cfg_idx_t'(cfg_index) == mkt_pkg::REG_SINE);

    mkt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (proc),
        .item  (in_item_reg),
        .spu   (spu_reg),
        .st    (seq_st)
    );

    mkt_osc u_osc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (seq_st.tone),
        .reseed    (reseed),
        .seed      ($signed(cfg_data[mkt_pkg::OSC_W-1:0])),
        .coeff     (coeff_reg),
        .amplitude (amp_reg),
        .sample    (osc_sample)
    );

    // configuration writes
    always_comb
    begin
        spu_next   = spu_reg;
        coeff_next = coeff_reg;
        amp_next   = amp_reg;
        if (cfg_wen)
        begin
            case (mkt_pkg::cfg_idx_t'(cfg_index))
                mkt_pkg::REG_SPU:   spu_next   = cfg_data[mkt_pkg::SPU_W-1:0];
                mkt_pkg::REG_COEFF: coeff_next = $signed(cfg_data[mkt_pkg::OSC_W-1:0]);
                mkt_pkg::REG_AMP:   amp_next   = cfg_data[mkt_pkg::AMP_W-1:0];
                default:            spu_next   = spu_reg;
            endcase
        end
    end

    // input and result stages
    always_comb
    begin
        in_vld_next   = in_vld_reg;
        in_item_next  = in_item_reg;
        out_vld_next  = out_vld_reg;
        out_item_next = out_item_reg;

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end
        if (proc)
        begin
            in_vld_next = 1'b0;
            if (seq_st.result)
            begin
                out_vld_next          = 1'b1;
                out_item_next.sample  = seq_st.tone ? osc_sample : '0;
                out_item_next.tone_on = seq_st.tone;
                out_item_next.last    = seq_st.last;
            end
        end
        if (in_valid && in_ready)
        begin
            in_vld_next  = 1'b1;
            in_item_next = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            spu_reg     <= mkt_pkg::SPU_RST;
            coeff_reg   <= mkt_pkg::COEFF_RST;
            amp_reg     <= mkt_pkg::AMP_RST;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            spu_reg     <= spu_next;
            coeff_reg   <= coeff_next;
            amp_reg     <= amp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

`ifndef SYNTH
    // the final sample of a symbol returns the sequencer to idle
    a_last_ends_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && seq_st.result && seq_st.last) |=> !seq_st.busy)
        else $error("sequencer still busy after last sample");

    // silent units carry a zero sample
    a_silence_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.tone_on) |-> (out_data.sample == '0))
        else $error("non-zero sample in a silent unit");

    // saturation keeps the sample off the most negative code
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.sample != {1'b1, {(mkt_pkg::PCM_W-1){1'b0}}}))
        else $error("sample outside the symmetric pcm range");

    // results come only from ticks seen while busy
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && seq_st.result) |-> (seq_st.busy && (in_item_reg.action == mkt_pkg::ACT_TICK)))
        else $error("result without a busy tick");
`endif

endmodule

`default_nettype wire

### tb/sv/morse_keyer_tone_generator_tb.sv
// morse_keyer_tone_generator_tb: self-checking bench for the morse keyer tone generator
// predicts every pcm sample from its own keyer and resonator model and checks each transfer
// depends on mkt_pkg and morse_keyer_tone_generator
`default_nettype none

module morse_keyer_tone_generator_tb;

    localparam longint OSC_MAX   = 64'sd2147483647;
    localparam longint OSC_MIN   = -64'sd2147483648;
    localparam longint Q30_ONE   = 64'sd1 << 30;
    localparam longint PCM_LIMIT = 64'sd32767;
    localparam int     SETTLE    = 8;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    mkt_pkg::in_t                        in_data = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    mkt_pkg::out_t                       out_data;
    logic                                cfg_wen = 1'b0;
    logic [mkt_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [mkt_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    // keyer copy: settings
    logic [19:0] unit_len = 20'd2880;
    int          coeff_q30 = 32'h7FFF_FFFF;
    int          amp_level = 16384;

    // keyer copy: state
    longint      osc_prev = 0;
    longint      osc_cur = 0;
    logic [19:0] unit_count = '0;
    int          units_left = 0;
    int          tone_left = 0;
    bit          keyer_busy = 1'b0;

    mkt_pkg::out_t pcm_expected[$];
    int            mismatch_count = 0;
    int            gap_pct = 0;
    int            stall_pct = 0;

    morse_keyer_tone_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic mkt_pkg::in_t make_item(input logic action, input logic [1:0] symbol);
        mkt_pkg::in_t item;
        item.action = action;
        item.symbol = symbol;
        return item;
    endfunction

    function automatic void keyer_predict(input mkt_pkg::in_t item);
        mkt_pkg::out_t res;
        longint        scaled;
        longint        nxt;
        logic [19:0]   lim;
        res = '0;
        if (item.action == mkt_pkg::ACT_LOAD)
        begin
            if (keyer_busy)
                return;
            case (item.symbol)
                mkt_pkg::SYM_DIT:
                begin
                    units_left = 2;
                    tone_left = 1;
                end
                mkt_pkg::SYM_DAH:
                begin
                    units_left = 4;
                    tone_left = 3;
                end
                mkt_pkg::SYM_SPACE:
                begin
                    units_left = 2;
                    tone_left = 0;
                end
                default:
                    return;
            endcase
            unit_count = '0;
            keyer_busy = 1'b1;
            return;
        end
        if (!keyer_busy)
            return;
        if (tone_left > 0)
        begin
            res.tone_on = 1'b1;
            scaled = (osc_prev * longint'(amp_level)) / Q30_ONE;
            if (scaled > PCM_LIMIT)
                scaled = PCM_LIMIT;
            if (scaled < -PCM_LIMIT)
                scaled = -PCM_LIMIT;
            res.sample = scaled[15:0];
            nxt = ((longint'(coeff_q30) * osc_cur) >>> 30) - osc_prev;
            if (nxt > OSC_MAX)
                nxt = OSC_MAX;
            if (nxt < OSC_MIN)
                nxt = OSC_MIN;
            osc_prev = osc_cur;
            osc_cur = nxt;
        end
        lim = (unit_len == '0) ? 20'd1 : unit_len;
        unit_count = unit_count + 20'd1;
        if (unit_count >= lim || unit_count == '0)
        begin
            unit_count = '0;
            if (tone_left > 0)
                tone_left--;
            if (units_left > 0)
                units_left--;
            if (units_left == 0)
            begin
                keyer_busy = 1'b0;
                tone_left = 0;
                res.last = 1'b1;
            end
        end
        pcm_expected = {pcm_expected, res};
    endfunction

    always @(posedge clk)
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        mkt_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pcm_expected.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: sample %0d tone_on %0b last %0b",
                             out_data.sample, out_data.tone_on, out_data.last);
                mismatch_count++;
            end
            else
            begin
                want = pcm_expected.pop_front();
                if (out_data.sample !== want.sample || out_data.tone_on !== want.tone_on ||
                    out_data.last !== want.last)
                begin
                    if (mismatch_count < 10)
                        $display({"mismatch: expected sample %0d tone_on %0b last %0b,",
                                  " got %0d %0b %0b"},
                                 want.sample, want.tone_on, want.last,
                                 out_data.sample, out_data.tone_on, out_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_item(input mkt_pkg::in_t item);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        keyer_predict(item);
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(make_item(mkt_pkg::ACT_TICK, 2'($urandom_range(3))));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pcm_expected.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input mkt_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            mkt_pkg::REG_SPU:   unit_len = value[19:0];
            mkt_pkg::REG_COEFF: coeff_q30 = value;
            mkt_pkg::REG_SINE:
            begin
                osc_prev = 0;
                osc_cur = $signed(value);
            end
            mkt_pkg::REG_AMP:   amp_level = value[14:0];
            default:   ;
        endcase
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] spu, input logic [31:0] coeff,
                             input logic [31:0] sine, input logic [31:0] amp);
        drain();
        write_reg(mkt_pkg::REG_SPU, spu);
        write_reg(mkt_pkg::REG_COEFF, coeff);
        write_reg(mkt_pkg::REG_SINE, sine);
        write_reg(mkt_pkg::REG_AMP, amp);
    endtask

    task automatic random_config();
        int          pick;
        logic [31:0] spu;
        pick = $urandom_range(9);
        if (pick == 0)
            spu = 0;
        else if (pick == 1)
            spu = $urandom_range(6, 4);
        else
            spu = $urandom_range(3, 1);
        configure(spu, $urandom, $urandom_range(32'h8000_0000) - 32'h4000_0000,
                  $urandom_range(32767));
    endtask

    // ticks and unknown symbol while idle give nothing
    task automatic test_idle_items();
        send_item(make_item(mkt_pkg::ACT_TICK, mkt_pkg::SYM_DIT));
        send_item(make_item(mkt_pkg::ACT_LOAD, 2'b11));
        send_item(make_item(mkt_pkg::ACT_TICK, 2'b11));
    endtask

    // each symbol shape, with oscillator and sample saturation
    task automatic test_symbol_shapes();
        configure(1, 32'h8000_0000, 32'h4000_0000, 32767);
        send_item(make_item(mkt_pkg::ACT_LOAD, mkt_pkg::SYM_DIT));
        send_ticks(2);
        send_item(make_item(mkt_pkg::ACT_LOAD, mkt_pkg::SYM_DAH));
        send_ticks(4);
        send_item(make_item(mkt_pkg::ACT_LOAD, mkt_pkg::SYM_SPACE));
        send_ticks(2);
    endtask

    // zero unit length and a load while busy
    task automatic test_busy_zero_unit();
        configure(0, 32'h7FFF_FFFF, 32'hC000_0000, 0);
        send_item(make_item(mkt_pkg::ACT_LOAD, mkt_pkg::SYM_DIT));
        send_item(make_item(mkt_pkg::ACT_LOAD, mkt_pkg::SYM_DAH));
        send_ticks(2);
    endtask

    // unit length cut below the running count
    task automatic test_unit_shortened();
        configure(20'hFFFFF, 32'h5A82_7999, 32'h2D41_3CCC, 16384);
        send_item(make_item(mkt_pkg::ACT_LOAD, mkt_pkg::SYM_DAH));
        send_ticks(3);
        drain();
        write_reg(mkt_pkg::REG_SPU, 2);
        send_ticks(7);
    endtask

    task automatic test_random(input int idle_pct, input int stall_in, input int n_items);
        int         sent;
        int         next_cfg;
        int         ticks;
        logic [1:0] sym;
        gap_pct = idle_pct;
        stall_pct = stall_in;
        sent = 0;
        next_cfg = 0;
        while (sent < n_items)
        begin
            if (sent >= next_cfg)
            begin
                random_config();
                next_cfg = sent + 70;
            end
            if ($urandom_range(99) < 80)
            begin
                while (keyer_busy)
                begin
                    send_ticks(1);
                    sent++;
                end
                sym = 2'($urandom_range(2));
                send_item(make_item(mkt_pkg::ACT_LOAD, sym));
                ticks = ((sym == mkt_pkg::SYM_DAH) ? 4 : 2) * ((unit_len == '0) ? 1 : unit_len)
                        + $urandom_range(1);
                repeat (ticks)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        send_item(make_item(mkt_pkg::ACT_LOAD, 2'($urandom_range(3))));
                        sent++;
                    end
                    send_ticks(1);
                end
                sent += ticks + 1;
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                begin
                    send_item(make_item(1'($urandom_range(1)), 2'($urandom_range(3))));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_items();
        test_symbol_shapes();
        test_busy_zero_unit();
        test_unit_shortened();
        test_random(0, 0, 200);
        test_random(46, 0, 200);
        test_random(0, 46, 200);
        test_random(33, 33, 200);
        drain();
        if (mismatch_count == 0 && pcm_expected.size() == 0)
            $display("morse_keyer_tone_generator test passed");
        else
            $display("morse_keyer_tone_generator test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("morse_keyer_tone_generator test failed");
        $finish;
    end

endmodule

`default_nettype wire
